[rtl/pi_ctl_pkg.sv]
package pi_ctl_pkg;

  // Sample format: signed fixed point, Q16.16 at the default sizes
  localparam int DataWidth    = 32;
  localparam int FracBits     = 16;
  localparam int LimitWidth   = DataWidth - 1;
  localparam int PrevWidth    = DataWidth + 2;
  localparam int ProdWidth    = 2 * DataWidth;
  localparam int SumWidth     = 2 * DataWidth + 2;
  localparam int CfgAddrWidth = 3;

  typedef logic signed [DataWidth-1:0] data_t;
  typedef logic signed [PrevWidth-1:0] prev_t;
  typedef logic signed [ProdWidth-1:0] prod_t;
  typedef logic signed [SumWidth-1:0]  sum_t;
  typedef logic        [LimitWidth-1:0] lim_t;

  // Configuration register indexes
  typedef enum logic [CfgAddrWidth-1:0] {
    CfgCoefCurrent  = 3'd0,
    CfgCoefPrevious = 3'd1,
    CfgOutputLimit  = 3'd2,
    CfgFfGain       = 3'd3,
    CfgFfEnable     = 3'd4
  } cfg_idx_e;

  // Saturation flag on each result beat
  typedef enum logic [1:0] {
    SatNone = 2'd0,
    SatHigh = 2'd1,
    SatLow  = 2'd2
  } sat_e;

  typedef struct packed {
    data_t coef_current;
    data_t coef_previous;
    lim_t  output_limit;
    data_t ff_gain;
    logic  ff_enable;
  } cfg_t;

  typedef struct packed {
    data_t last_error;
    prev_t prev_output;
  } state_t;

endpackage

[rtl/pi_ctl_datapath.sv]
module pi_ctl_datapath (
  input  pi_ctl_pkg::cfg_t   cfg_i,
  input  pi_ctl_pkg::state_t state_i,
  input  pi_ctl_pkg::data_t  error_i,
  input  pi_ctl_pkg::data_t  reference_i,
  output pi_ctl_pkg::data_t  result_o,
  output pi_ctl_pkg::sat_e   status_o,
  output pi_ctl_pkg::state_t state_o
);

  localparam int Dw = pi_ctl_pkg::DataWidth;
  localparam int Pw = pi_ctl_pkg::ProdWidth;
  localparam int Fb = pi_ctl_pkg::FracBits;

  pi_ctl_pkg::prod_t p_cur;
  pi_ctl_pkg::prod_t p_prev;
  pi_ctl_pkg::prod_t p_ff;
  pi_ctl_pkg::prod_t p_ff_sh;
  pi_ctl_pkg::data_t ff_term;
  pi_ctl_pkg::data_t lim_pos;
  pi_ctl_pkg::sum_t  sum;
  pi_ctl_pkg::sum_t  sum_sh;
  pi_ctl_pkg::sum_t  hi_lim;
  pi_ctl_pkg::sum_t  lo_lim;
  logic              ff_fits;

  // Three independent full-precision products
  assign p_cur  = $signed(cfg_i.coef_current)  * $signed(error_i);
  assign p_prev = $signed(cfg_i.coef_previous) * $signed(state_i.last_error);
  assign p_ff   = $signed(cfg_i.ff_gain)       * $signed(reference_i);

  // Feedforward term, zero when disabled: floor to the output format, saturate to the data range
  assign p_ff_sh = p_ff >>> Fb;
  assign ff_fits = (&p_ff_sh[Pw-1:Dw-1]) || !(|p_ff_sh[Pw-1:Dw-1]);

  always_comb begin
    if (!cfg_i.ff_enable) begin
      ff_term = '0;
    end else if (ff_fits) begin
      ff_term = p_ff_sh[Dw-1:0];
    end else if (p_ff_sh[Pw-1]) begin
      ff_term = {1'b1, {(Dw-1){1'b0}}};
    end else begin
      ff_term = {1'b0, {(Dw-1){1'b1}}};
    end
  end

  // Exact sum at double fraction precision
  assign sum = pi_ctl_pkg::sum_t'(p_cur) + pi_ctl_pkg::sum_t'(p_prev)
             + (pi_ctl_pkg::sum_t'($signed(state_i.prev_output)) <<< Fb)
             + (pi_ctl_pkg::sum_t'(ff_term) <<< Fb);

  assign hi_lim  = pi_ctl_pkg::sum_t'({1'b0, cfg_i.output_limit}) <<< Fb;
  assign lo_lim  = -hi_lim;
  assign sum_sh  = sum >>> Fb;
  assign lim_pos = {1'b0, cfg_i.output_limit};

  // Symmetric clamp
  always_comb begin
    if (sum > hi_lim) begin
      result_o = lim_pos;
      status_o = pi_ctl_pkg::SatHigh;
    end else if (sum < lo_lim) begin
      result_o = -lim_pos;
      status_o = pi_ctl_pkg::SatLow;
    end else begin
      result_o = sum_sh[Dw-1:0];
      status_o = pi_ctl_pkg::SatNone;
    end
  end

  // Next state; feedforward mode removes the ff term and holds error on clamp
  always_comb begin
    if (cfg_i.ff_enable) begin
      state_o.prev_output = pi_ctl_pkg::prev_t'(result_o) - pi_ctl_pkg::prev_t'(ff_term);
      state_o.last_error  = (status_o == pi_ctl_pkg::SatNone) ? error_i
                                                              : state_i.last_error;
    end else begin
      state_o.prev_output = pi_ctl_pkg::prev_t'(result_o);
      state_o.last_error  = error_i;
    end
  end

endmodule

[rtl/pi_controller_saturating_ff_unit.sv]
// Discrete PI controller (Tustin form) with optional feedforward and
// anti-windup, Q16.16 signed fixed point.
// Input channel (in_valid_i / in_ready_o): one beat per control tick carries
// error_in_i and reference_i. Output channel (out_valid_o / out_ready_i):
// one beat per input beat, control_output_o and sat_status_o
// (0 within limits, 1 clamped high, 2 clamped low).
// A beat taken on the input channel sits in the input register and then
// moves to the result register, where out_valid_o is high.
// Throughput: one beat per cycle while out_ready_i is high; an input
// register feeds the multiply, sum and clamp logic, which writes the result
// register and the controller state in the same cycle, so the next sample
// sees the updated state.
// When the receiver stalls, the result register holds; the input register
// takes one more beat only if empty; in_ready_o is low while it is full.
// Configuration: cfg_we_i writes cfg_data_i into register cfg_addr_i
// (0 coef_current, 1 coef_previous, 2 output_limit, 3 ff_gain,
// 4 ff_enable); write only while the block is idle.
// Reset clears all configuration registers, last error and previous output
// to zero, and empties both stages.
module pi_controller_saturating_ff_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pi_ctl_pkg::CfgAddrWidth-1:0] cfg_addr_i,
  input  logic [pi_ctl_pkg::DataWidth-1:0]    cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [pi_ctl_pkg::DataWidth-1:0] error_in_i,
  input  logic signed [pi_ctl_pkg::DataWidth-1:0] reference_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [pi_ctl_pkg::DataWidth-1:0] control_output_o,
  output logic [1:0]                          sat_status_o
);

  pi_ctl_pkg::cfg_t   cfg_q;
  pi_ctl_pkg::state_t state_q;
  pi_ctl_pkg::state_t state_d;
  pi_ctl_pkg::data_t  err_q;
  pi_ctl_pkg::data_t  ref_q;
  pi_ctl_pkg::data_t  result_d;
  pi_ctl_pkg::data_t  result_q;
  pi_ctl_pkg::sat_e   status_d;
  pi_ctl_pkg::sat_e   status_q;
  logic               in_valid_q;
  logic               out_valid_q;
  logic               in_take;
  logic               advance;

  // Handshake: the input stage moves on whenever the result register is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;
  assign in_take    = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (pi_ctl_pkg::cfg_idx_e'(cfg_addr_i))
        pi_ctl_pkg::CfgCoefCurrent:  cfg_q.coef_current  <= cfg_data_i;
        pi_ctl_pkg::CfgCoefPrevious: cfg_q.coef_previous <= cfg_data_i;
        pi_ctl_pkg::CfgOutputLimit:
          cfg_q.output_limit <= cfg_data_i[pi_ctl_pkg::LimitWidth-1:0];
        pi_ctl_pkg::CfgFfGain:       cfg_q.ff_gain       <= cfg_data_i;
        pi_ctl_pkg::CfgFfEnable:     cfg_q.ff_enable     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Valid flags of the input and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Input sample register
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      err_q <= error_in_i;
      ref_q <= reference_i;
    end
  end

  pi_ctl_datapath u_datapath (
    .cfg_i       (cfg_q),
    .state_i     (state_q),
    .error_i     (err_q),
    .reference_i (ref_q),
    .result_o    (result_d),
    .status_o    (status_d),
    .state_o     (state_d)
  );

  // Controller state follows each sample as it leaves the input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= result_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign control_output_o = result_q;
  assign sat_status_o     = status_q;

endmodule
